// File: rtl/bsf_pkg.sv
package bsf_pkg;

    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_CONTAINS = 2'd2;

    localparam logic [31:0] SEED_A    = 32'h0009_3498;
    localparam logic [31:0] SEED_B    = 32'h0002_2745;
    localparam logic [31:0] KEY_BYTES = 32'd2;
    localparam logic [31:0] MIX_C1    = 32'hcc9e_2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b87_3593;
    localparam logic [31:0] FMIX_C1   = 32'h85eb_ca6b;
    localparam logic [31:0] FMIX_C2   = 32'hc2b2_ae35;

    typedef enum logic [5:0] {
        HS_K1 = 6'b000001,
        HS_K2 = 6'b000010,
        HS_A1 = 6'b000100,
        HS_A2 = 6'b001000,
        HS_B1 = 6'b010000,
        HS_B2 = 6'b100000
    } hash_step_t;

    typedef struct packed {
        logic        start;
        logic [15:0] key;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] ha;
        logic [31:0] hb;
    } hash_rsp_t;

endpackage

// File: rtl/bsf_hash.sv
module bsf_hash
(
    input  logic               clk,
    input  logic               rst_n,
    input  bsf_pkg::hash_req_t req,
    output bsf_pkg::hash_rsp_t rsp
);

    bsf_pkg::hash_step_t step_reg;
    bsf_pkg::hash_step_t step_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [31:0]         k_reg;
    logic [31:0]         ha_reg;
    logic [31:0]         hb_reg;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [31:0]         product;
    logic [31:0]         pre_a;
    logic [31:0]         pre_b;

    assign pre_a   = bsf_pkg::SEED_A ^ k_reg ^ bsf_pkg::KEY_BYTES;
    assign pre_b   = bsf_pkg::SEED_B ^ k_reg ^ bsf_pkg::KEY_BYTES;
    assign product = mul_a * mul_b;

    always_comb
    begin
        case (step_reg)
            bsf_pkg::HS_K1:
            begin
                mul_a = k_reg;
                mul_b = bsf_pkg::MIX_C1;
            end
            bsf_pkg::HS_K2:
            begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = bsf_pkg::MIX_C2;
            end
            bsf_pkg::HS_A1:
            begin
                mul_a = pre_a ^ (pre_a >> 16);
                mul_b = bsf_pkg::FMIX_C1;
            end
            bsf_pkg::HS_A2:
            begin
                mul_a = ha_reg ^ (ha_reg >> 13);
                mul_b = bsf_pkg::FMIX_C2;
            end
            bsf_pkg::HS_B1:
            begin
                mul_a = pre_b ^ (pre_b >> 16);
                mul_b = bsf_pkg::FMIX_C1;
            end
            bsf_pkg::HS_B2:
            begin
                mul_a = hb_reg ^ (hb_reg >> 13);
                mul_b = bsf_pkg::FMIX_C2;
            end
            default:
            begin
                mul_a = k_reg;
                mul_b = bsf_pkg::MIX_C1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (step_reg == bsf_pkg::HS_B2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                step_next = bsf_pkg::HS_K1;
            end
            else
            begin
                step_next = bsf_pkg::hash_step_t'({step_reg[4:0], 1'b0});
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = bsf_pkg::HS_K1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bsf_pkg::HS_K1;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            k_reg <= {16'd0, req.key};
        end
        else if (busy_reg)
        begin
            case (step_reg)
                bsf_pkg::HS_K1, bsf_pkg::HS_K2: k_reg  <= product;
                bsf_pkg::HS_A1, bsf_pkg::HS_A2: ha_reg <= product;
                bsf_pkg::HS_B1, bsf_pkg::HS_B2: hb_reg <= product;
                default:                        k_reg  <= k_reg;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ha   = ha_reg ^ (ha_reg >> 16);
    assign rsp.hb   = hb_reg ^ (hb_reg >> 16);

endmodule

// File: rtl/small_set_with_bloom_filter.sv
// Ordered set of up to CAPACITY distinct 16-bit values with a 32-bit filter word
// built from two MurmurHash3 x86_32 hashes per value. Each input beat carries a
// mode (add, remove, contains) and a value, and yields exactly one output beat
// with ok, found and the entry count after the operation. The block handles one
// beat at a time and drops s_tready until the result is registered; an output
// beat may wait on m_tready while the next input beat is taken. Cost is set by a
// walk over the entry RAM (read, then compare or move) and by one shared 32x32
// multiplier that steps through K1, K2, A1, A2, B1 and B2 for each hash pair.
// Contains answers without hashing for an empty filter, after the hash for a
// rejecting filter, and otherwise after a search of the entries; add fails when
// full, else searches the entries and hashes only a new value; remove searches
// and shifts, then rebuilds the filter by hashing every remaining entry. No
// clearing pass is needed after reset.
module small_set_with_bloom_filter
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[1:0], value[17:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok[0], found[1], count[10:2], zero pad
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SRCH_RD  = 9'b000000010,
        ST_SRCH_CMP = 9'b000000100,
        ST_HSTART   = 9'b000001000,
        ST_HWAIT    = 9'b000010000,
        ST_SHIFT_RD = 9'b000100000,
        ST_SHIFT_WR = 9'b001000000,
        ST_REB_RD   = 9'b010000000,
        ST_RESP     = 9'b100000000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [15:0]        value_reg;
    logic [15:0]        value_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [31:0]        filter_reg;
    logic [31:0]        filter_next;
    logic               ok_reg;
    logic               ok_next;
    logic               found_reg;
    logic               found_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [15:0]        m_tdata_reg;
    logic [15:0]        m_tdata_next;

    logic [15:0]        mem [CAPACITY];
    logic [15:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [15:0]        mem_wdata;

    bsf_pkg::hash_req_t hreq;
    bsf_pkg::hash_rsp_t hrsp;
    logic [31:0]        hash_bits;

    bsf_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    assign hash_bits = hrsp.ha | hrsp.hb;
    assign idx_inc   = CW'(idx_reg + 1'b1);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        value_next    = value_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        filter_next   = filter_reg;
        ok_next       = ok_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = idx_reg[AW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[AW-1:0];
        mem_wdata     = rd_data_reg;
        hreq.start    = 1'b0;
        hreq.key      = value_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tdata[1:0];
                    value_next = s_tdata[17:2];
                    idx_next   = '0;
                    ok_next    = 1'b1;
                    found_next = 1'b0;
                    case (s_tdata[1:0])
                        bsf_pkg::MODE_ADD:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                ok_next    = 1'b0;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        bsf_pkg::MODE_REMOVE:
                        begin
                            state_next = ST_SRCH_RD;
                        end
                        bsf_pkg::MODE_CONTAINS:
                        begin
                            state_next = (filter_reg == 32'd0) ? ST_RESP : ST_HSTART;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SRCH_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    case (mode_reg)
                        bsf_pkg::MODE_ADD:
                        begin
                            state_next = ST_HSTART;
                        end
                        bsf_pkg::MODE_REMOVE:
                        begin
                            idx_next    = '0;
                            filter_next = 32'd0;
                            state_next  = ST_REB_RD;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end

            ST_SRCH_CMP:
            begin
                if (rd_data_reg == value_reg)
                begin
                    case (mode_reg)
                        bsf_pkg::MODE_ADD:
                        begin
                            state_next = ST_RESP;
                        end
                        bsf_pkg::MODE_REMOVE:
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                        default:
                        begin
                            found_next = 1'b1;
                            state_next = ST_RESP;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                rd_addr = idx_inc[AW-1:0];
                if (idx_inc >= count_reg)
                begin
                    count_next  = CW'(count_reg - 1'b1);
                    idx_next    = '0;
                    filter_next = 32'd0;
                    state_next  = ST_REB_RD;
                end
                else
                begin
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_inc;
                state_next = ST_SHIFT_RD;
            end

            ST_REB_RD:
            begin
                state_next = (idx_reg >= count_reg) ? ST_RESP : ST_HSTART;
            end

            ST_HSTART:
            begin
                hreq.start = 1'b1;
                hreq.key   = (mode_reg == bsf_pkg::MODE_REMOVE) ? rd_data_reg : value_reg;
                state_next = ST_HWAIT;
            end

            ST_HWAIT:
            begin
                if (hrsp.done)
                begin
                    case (mode_reg)
                        bsf_pkg::MODE_ADD:
                        begin
                            filter_next = filter_reg | hash_bits;
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[AW-1:0];
                            mem_wdata   = value_reg;
                            count_next  = CW'(count_reg + 1'b1);
                            state_next  = ST_RESP;
                        end
                        bsf_pkg::MODE_REMOVE:
                        begin
                            filter_next = filter_reg | hash_bits;
                            idx_next    = idx_inc;
                            state_next  = ST_REB_RD;
                        end
                        default:
                        begin
                            if (((filter_reg & hrsp.ha) == hrsp.ha) &&
                                ((filter_reg & hrsp.hb) == hrsp.hb))
                            begin
                                idx_next   = '0;
                                state_next = ST_SRCH_RD;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                    endcase
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, 9'(count_reg), found_reg, ok_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            filter_reg   <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            filter_reg   <= filter_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: rtl/bsf_chk.sv
module bsf_chk
#(
    parameter int CAPACITY = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:2] <= 9'(CAPACITY)))
        else $error("count above capacity");

    a_found_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("found set on a failed operation");

endmodule

bind small_set_with_bloom_filter bsf_chk #(.CAPACITY(CAPACITY)) u_bsf_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
